// ----- sv/smte_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted multi-timer engine package
// Shared constants, request and response types, and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package smte_pkg;

   localparam int TIMER_SLOTS = 16;
   localparam int SLOT_W      = $clog2(TIMER_SLOTS);
   localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);

   localparam logic [2:0] OP_ALLOC = 3'd0;
   localparam logic [2:0] OP_FREE  = 3'd1;
   localparam logic [2:0] OP_INIT  = 3'd2;
   localparam logic [2:0] OP_ARM   = 3'd3;
   localparam logic [2:0] OP_TICK  = 3'd4;

   localparam logic [1:0] KIND_REPLY  = 2'd0;
   localparam logic [1:0] KIND_EXPIRY = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [1:0] ST_FREE  = 2'd0;
   localparam logic [1:0] ST_ALLOC = 2'd1;
   localparam logic [1:0] ST_ARMED = 2'd2;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [3:0]  slot_index;
      logic [31:0] delay_ticks;
      logic [31:0] event_word;
      logic [2:0]  dest_queue;
   } req_type;

   typedef struct packed {
      logic [1:0]  reply_kind;
      logic [3:0]  timer_slot;
      logic [31:0] expired_word;
      logic [2:0]  expired_queue;
      logic        is_last;
   } rsp_type;

   typedef enum logic [2:0] {
      OUT_NONE,
      OUT_REPLY_REQ,
      OUT_REPLY_PTR,
      OUT_ERROR_REQ,
      OUT_ERROR_ZERO,
      OUT_EXPIRY
   } out_sel_type;

   typedef struct packed {
      logic        load_req;
      logic        ptr_clear;
      logic        ptr_inc;
      logic        scan_alloc;
      logic        alloc_take;
      logic        free_slot;
      logic        init_write;
      logic        arm_setup;
      logic        arm_insert;
      logic        unlink;
      logic        tick_inc;
      logic        pop;
      out_sel_type out_sel;
   } cmd_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic       slot_ok;
      logic [1:0] slot_status;
      logic       ptr_last;
      logic       ptr_end;
      logic       list_lt;
      logic       list_match;
      logic       head_due;
      logic       next_due;
      logic       out_free;
   } sts_type;

endpackage

// ----- sv/smte_dp.sv -----
// ----------------------------------------------------------------------------
// Sorted multi-timer engine datapath
// Tick counter, slot status, deadline-sorted list, slot event memory and the
// response register, all driven by commands from the controller.
// ----------------------------------------------------------------------------
module smte_dp (
   input  logic              clock,
   input  logic              reset,
   input  smte_pkg::req_type req_data,
   input  smte_pkg::cmd_type cmd,
   output smte_pkg::sts_type sts,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output smte_pkg::rsp_type rsp_data
);

   smte_pkg::req_type                  req_ff;
   logic [31:0]                        tick_ff, tick_in;
   logic [31:0]                        deadline_ff, deadline_in;
   logic [1:0]                         status_ff [smte_pkg::TIMER_SLOTS];
   logic [1:0]                         status_in [smte_pkg::TIMER_SLOTS];
   logic [smte_pkg::SLOT_W-1:0]        list_slot_ff [smte_pkg::TIMER_SLOTS];
   logic [smte_pkg::SLOT_W-1:0]        list_slot_in [smte_pkg::TIMER_SLOTS];
   logic [31:0]                        list_dl_ff [smte_pkg::TIMER_SLOTS];
   logic [31:0]                        list_dl_in [smte_pkg::TIMER_SLOTS];
   logic [smte_pkg::CNT_W-1:0]         armed_ff, armed_in;
   logic [smte_pkg::CNT_W-1:0]         ptr_ff, ptr_in;
   logic [34:0]                        slot_data_mem [smte_pkg::TIMER_SLOTS];
   logic [34:0]                        mem_rd_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   smte_pkg::rsp_type                  rsp_ff, rsp_in, rsp_item;
   logic [smte_pkg::SLOT_W-1:0]        req_slot, ptr_idx, head_slot, stat_idx;

   assign req_slot  = smte_pkg::SLOT_W'(req_ff.slot_index);
   assign ptr_idx   = ptr_ff[smte_pkg::SLOT_W-1:0];
   assign head_slot = list_slot_ff[0];
   assign stat_idx  = cmd.scan_alloc ? ptr_idx : req_slot;

   always_comb begin
      sts.opcode      = req_ff.opcode;
      sts.slot_ok     = int'(req_ff.slot_index) < smte_pkg::TIMER_SLOTS;
      sts.slot_status = status_ff[stat_idx];
      sts.ptr_last    = ptr_ff == smte_pkg::CNT_W'(smte_pkg::TIMER_SLOTS - 1);
      sts.ptr_end     = ptr_ff == armed_ff;
      sts.list_lt     = list_dl_ff[ptr_idx] < deadline_ff;
      sts.list_match  = list_slot_ff[ptr_idx] == req_slot;
      sts.head_due    = (armed_ff != '0) && (list_dl_ff[0] <= tick_ff);
      sts.next_due    = (armed_ff > smte_pkg::CNT_W'(1)) && (list_dl_ff[1] <= tick_ff);
      sts.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      ptr_in      = ptr_ff;
      tick_in     = tick_ff;
      deadline_in = deadline_ff;
      armed_in    = armed_ff;
      status_in   = status_ff;
      list_slot_in = list_slot_ff;
      list_dl_in   = list_dl_ff;

      if (cmd.ptr_clear) begin
         ptr_in = '0;
      end else if (cmd.ptr_inc) begin
         ptr_in = ptr_ff + smte_pkg::CNT_W'(1);
      end
      if (cmd.tick_inc) begin
         tick_in = tick_ff + 32'd1;
      end
      if (cmd.arm_setup) begin
         deadline_in = req_ff.delay_ticks + tick_ff;
      end
      if (cmd.alloc_take) begin
         status_in[ptr_idx] = smte_pkg::ST_ALLOC;
      end
      if (cmd.free_slot) begin
         status_in[req_slot] = smte_pkg::ST_FREE;
      end
      if (cmd.arm_insert) begin
         status_in[req_slot] = smte_pkg::ST_ARMED;
         armed_in = armed_ff + smte_pkg::CNT_W'(1);
         for (int q = 1; q < smte_pkg::TIMER_SLOTS; q++) begin
            if (smte_pkg::CNT_W'(q) > ptr_ff) begin
               list_slot_in[q] = list_slot_ff[q-1];
               list_dl_in[q]   = list_dl_ff[q-1];
            end
         end
         list_slot_in[ptr_idx] = req_slot;
         list_dl_in[ptr_idx]   = deadline_ff;
      end
      if (cmd.unlink) begin
         armed_in = armed_ff - smte_pkg::CNT_W'(1);
         for (int q = 0; q < smte_pkg::TIMER_SLOTS - 1; q++) begin
            if (smte_pkg::CNT_W'(q) >= ptr_ff) begin
               list_slot_in[q] = list_slot_ff[q+1];
               list_dl_in[q]   = list_dl_ff[q+1];
            end
         end
      end
      if (cmd.pop) begin
         status_in[head_slot] = smte_pkg::ST_ALLOC;
         armed_in = armed_ff - smte_pkg::CNT_W'(1);
         for (int q = 0; q < smte_pkg::TIMER_SLOTS - 1; q++) begin
            list_slot_in[q] = list_slot_ff[q+1];
            list_dl_in[q]   = list_dl_ff[q+1];
         end
      end
   end

   always_comb begin
      rsp_item = '0;
      rsp_item.is_last = 1'b1;
      case (cmd.out_sel)
         smte_pkg::OUT_REPLY_REQ: begin
            rsp_item.reply_kind = smte_pkg::KIND_REPLY;
            rsp_item.timer_slot = req_ff.slot_index;
         end
         smte_pkg::OUT_REPLY_PTR: begin
            rsp_item.reply_kind = smte_pkg::KIND_REPLY;
            rsp_item.timer_slot = 4'(ptr_idx);
         end
         smte_pkg::OUT_ERROR_REQ: begin
            rsp_item.reply_kind = smte_pkg::KIND_ERROR;
            rsp_item.timer_slot = req_ff.slot_index;
         end
         smte_pkg::OUT_ERROR_ZERO: begin
            rsp_item.reply_kind = smte_pkg::KIND_ERROR;
         end
         smte_pkg::OUT_EXPIRY: begin
            rsp_item.reply_kind    = smte_pkg::KIND_EXPIRY;
            rsp_item.timer_slot    = 4'(head_slot);
            rsp_item.expired_word  = mem_rd_ff[34:3];
            rsp_item.expired_queue = mem_rd_ff[2:0];
            rsp_item.is_last       = !sts.next_due;
         end
         default: begin
            rsp_item = '0;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_sel != smte_pkg::OUT_NONE) begin
         rsp_valid_in = 1'b1;
         rsp_in       = rsp_item;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
         rsp_in       = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= '0;
         armed_ff     <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < smte_pkg::TIMER_SLOTS; s++) begin
            status_ff[s] <= smte_pkg::ST_FREE;
         end
      end else begin
         tick_ff      <= tick_in;
         armed_ff     <= armed_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      deadline_ff  <= deadline_in;
      list_slot_ff <= list_slot_in;
      list_dl_ff   <= list_dl_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.init_write) begin
         slot_data_mem[req_slot] <= {req_ff.event_word, req_ff.dest_queue};
      end
      mem_rd_ff <= slot_data_mem[head_slot];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_armed_bound: assert property (@(posedge clock) disable iff (reset)
      armed_ff <= smte_pkg::CNT_W'(smte_pkg::TIMER_SLOTS))
      else $error("Armed count exceeds the number of slots.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_sel != smte_pkg::OUT_NONE |-> !(rsp_valid_ff && rsp_stall))
      else $error("Response register overwritten while stalled.");

   a_pop_due: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> sts.head_due)
      else $error("Expiry of a timer that is not due.");

   a_insert_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.arm_insert |-> (armed_ff < smte_pkg::CNT_W'(smte_pkg::TIMER_SLOTS))
                         && (status_ff[req_slot] == smte_pkg::ST_ALLOC))
      else $error("Insert into a full list or of a slot that is not allocated.");

   a_unlink_match: assert property (@(posedge clock) disable iff (reset)
      cmd.unlink |-> sts.list_match && !sts.ptr_end)
      else $error("Unlink at an entry that does not hold the slot.");

endmodule

// ----- sv/smte_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sorted multi-timer engine controller
// State machine that decodes each request and steps the datapath through
// the slot scan, list walk, insert, unlink and expiry sequences.
// ----------------------------------------------------------------------------
module smte_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  smte_pkg::sts_type sts,
   output smte_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_ALLOC_SCAN,
      S_UNLINK_SCAN,
      S_FREE_DONE,
      S_INIT_DONE,
      S_INSERT_SCAN,
      S_ERROR,
      S_EXP_CHECK,
      S_EXP_EMIT
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.ptr_clear = 1'b1;
            case (sts.opcode)
               smte_pkg::OP_ALLOC: begin
                  state_in = S_ALLOC_SCAN;
               end
               smte_pkg::OP_FREE: begin
                  if (!sts.slot_ok) begin
                     state_in = S_ERROR;
                  end else if (sts.slot_status == smte_pkg::ST_ARMED) begin
                     state_in = S_UNLINK_SCAN;
                  end else begin
                     state_in = S_FREE_DONE;
                  end
               end
               smte_pkg::OP_INIT: begin
                  state_in = sts.slot_ok ? S_INIT_DONE : S_ERROR;
               end
               smte_pkg::OP_ARM: begin
                  if (!sts.slot_ok || sts.slot_status != smte_pkg::ST_ALLOC) begin
                     state_in = S_ERROR;
                  end else begin
                     cmd.arm_setup = 1'b1;
                     state_in      = S_INSERT_SCAN;
                  end
               end
               smte_pkg::OP_TICK: begin
                  cmd.tick_inc = 1'b1;
                  state_in     = S_EXP_CHECK;
               end
               default: begin
                  state_in = S_ERROR;
               end
            endcase
         end
         S_ALLOC_SCAN: begin
            cmd.scan_alloc = 1'b1;
            if (sts.slot_status == smte_pkg::ST_FREE) begin
               if (sts.out_free) begin
                  cmd.alloc_take = 1'b1;
                  cmd.out_sel    = smte_pkg::OUT_REPLY_PTR;
                  state_in       = S_IDLE;
               end
            end else if (sts.ptr_last) begin
               if (sts.out_free) begin
                  cmd.out_sel = smte_pkg::OUT_ERROR_ZERO;
                  state_in    = S_IDLE;
               end
            end else begin
               cmd.ptr_inc = 1'b1;
            end
         end
         S_UNLINK_SCAN: begin
            if (sts.list_match) begin
               cmd.unlink = 1'b1;
               state_in   = S_FREE_DONE;
            end else begin
               cmd.ptr_inc = 1'b1;
            end
         end
         S_FREE_DONE: begin
            if (sts.out_free) begin
               cmd.free_slot = 1'b1;
               cmd.out_sel   = smte_pkg::OUT_REPLY_REQ;
               state_in      = S_IDLE;
            end
         end
         S_INIT_DONE: begin
            if (sts.out_free) begin
               cmd.init_write = 1'b1;
               cmd.out_sel    = smte_pkg::OUT_REPLY_REQ;
               state_in       = S_IDLE;
            end
         end
         S_INSERT_SCAN: begin
            if (!sts.ptr_end && sts.list_lt) begin
               cmd.ptr_inc = 1'b1;
            end else if (sts.out_free) begin
               cmd.arm_insert = 1'b1;
               cmd.out_sel    = smte_pkg::OUT_REPLY_REQ;
               state_in       = S_IDLE;
            end
         end
         S_ERROR: begin
            if (sts.out_free) begin
               cmd.out_sel = smte_pkg::OUT_ERROR_REQ;
               state_in    = S_IDLE;
            end
         end
         S_EXP_CHECK: begin
            state_in = sts.head_due ? S_EXP_EMIT : S_IDLE;
         end
         S_EXP_EMIT: begin
            if (sts.out_free) begin
               cmd.pop     = 1'b1;
               cmd.out_sel = smte_pkg::OUT_EXPIRY;
               state_in    = sts.next_due ? S_EXP_CHECK : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- sv/sorted_multi_timer_engine_core.sv -----
// ----------------------------------------------------------------------------
// Sorted multi-timer engine
// A pool of timer slots multiplexed onto one 32-bit tick, with alloc, free,
// init, arm and tick requests and a deadline-sorted list of armed timers.
// ----------------------------------------------------------------------------
// One request is handled at a time. Alloc scans the slots in order for a free
// one, arm walks past the armed timers with an earlier deadline, and free of
// an armed timer first walks the list to its entry and unlinks it. A tick
// emits one expiry per due timer, taking its event data from a registered
// read of the slot event memory. The controller walks the sorted list one
// entry per cycle, and each final response waits while a response in the
// output register is stalled. A response that waits in the output register
// delays only the next response, not the acceptance of the next request.
module sorted_multi_timer_engine_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  smte_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output smte_pkg::rsp_type rsp_data
);

   smte_pkg::cmd_type cmd;
   smte_pkg::sts_type sts;

   smte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   smte_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// Sorted multi-timer engine testbench
// Sends alloc, free, init, arm and tick requests with random idle cycles on
// both channels. A model of the timer pool and its deadline-sorted list
// predicts every reply and expiry event, and each response is compared with
// the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
   localparam int MAX_EXPIRIES    = 16;
   localparam int RANDOM_REQUESTS = 440;
   localparam int REPORT_LIMIT    = 10;
   localparam int SETTLE_CYCLES   = 64;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   smte_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   smte_pkg::rsp_type rsp_data;

   bit                no_idle        = 1'b0;
   int                mismatch_total = 0;
   smte_pkg::rsp_type owed_replies[$];

   logic [1:0]  slot_state  [smte_pkg::TIMER_SLOTS];
   logic [31:0] slot_due    [smte_pkg::TIMER_SLOTS];
   logic [31:0] slot_word   [smte_pkg::TIMER_SLOTS];
   logic [2:0]  slot_dest   [smte_pkg::TIMER_SLOTS];
   bit          slot_loaded [smte_pkg::TIMER_SLOTS];
   int          armed_list[$];
   logic [31:0] tick_now;

   sorted_multi_timer_engine_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99) < 21);
   end

   function automatic void owe_reply(logic [1:0] kind, int slot, logic [31:0] word,
                                     logic [2:0] dest, logic last);
      smte_pkg::rsp_type r;
      r.reply_kind    = kind;
      r.timer_slot    = 4'(slot);
      r.expired_word  = word;
      r.expired_queue = dest;
      r.is_last       = last;
      owed_replies.push_back(r);
   endfunction

   function automatic void timer_pool_apply(smte_pkg::req_type req);
      int s;
      int p;
      int n;
      s = req.slot_index;
      case (req.opcode)
         smte_pkg::OP_ALLOC: begin
            p = 0;
            while (p < smte_pkg::TIMER_SLOTS && slot_state[p] != smte_pkg::ST_FREE) p++;
            if (p < smte_pkg::TIMER_SLOTS) begin
               slot_state[p] = smte_pkg::ST_ALLOC;
               owe_reply(smte_pkg::KIND_REPLY, p, '0, '0, 1'b1);
            end else begin
               owe_reply(smte_pkg::KIND_ERROR, 0, '0, '0, 1'b1);
            end
         end
         smte_pkg::OP_FREE: begin
            p = 0;
            while (p < armed_list.size() && armed_list[p] != s) p++;
            if (p < armed_list.size()) armed_list.delete(p);
            slot_state[s] = smte_pkg::ST_FREE;
            owe_reply(smte_pkg::KIND_REPLY, s, '0, '0, 1'b1);
         end
         smte_pkg::OP_INIT: begin
            slot_word[s]   = req.event_word;
            slot_dest[s]   = req.dest_queue;
            slot_loaded[s] = 1'b1;
            owe_reply(smte_pkg::KIND_REPLY, s, '0, '0, 1'b1);
         end
         smte_pkg::OP_ARM: begin
            if (slot_state[s] != smte_pkg::ST_ALLOC) begin
               owe_reply(smte_pkg::KIND_ERROR, s, '0, '0, 1'b1);
            end else begin
               slot_due[s]   = req.delay_ticks + tick_now;
               slot_state[s] = smte_pkg::ST_ARMED;
               p = 0;
               while (p < armed_list.size() && slot_due[armed_list[p]] < slot_due[s]) p++;
               armed_list.insert(p, s);
               owe_reply(smte_pkg::KIND_REPLY, s, '0, '0, 1'b1);
            end
         end
         smte_pkg::OP_TICK: begin
            tick_now = tick_now + 32'd1;
            n = 0;
            while (n < armed_list.size() && n < MAX_EXPIRIES &&
                   slot_due[armed_list[n]] <= tick_now) n++;
            for (p = 0; p < n; p++) begin
               slot_state[armed_list[p]] = smte_pkg::ST_ALLOC;
               owe_reply(smte_pkg::KIND_EXPIRY, armed_list[p], slot_word[armed_list[p]],
                         slot_dest[armed_list[p]], p == n - 1);
            end
            repeat (n) void'(armed_list.pop_front());
         end
         default: begin
            owe_reply(smte_pkg::KIND_ERROR, s, '0, '0, 1'b1);
         end
      endcase
   endfunction

   function automatic void report_mismatch(string what, smte_pkg::rsp_type want,
                                           smte_pkg::rsp_type got);
      mismatch_total++;
      if (mismatch_total <= REPORT_LIMIT)
         $display("%s at %0t: expected kind %0d slot %0d word %h queue %0d last %0b, %s",
                  what, $time, want.reply_kind, want.timer_slot, want.expired_word,
                  want.expired_queue, want.is_last,
                  $sformatf("got kind %0d slot %0d word %h queue %0d last %0b",
                            got.reply_kind, got.timer_slot, got.expired_word,
                            got.expired_queue, got.is_last));
   endfunction

   always @(posedge clock) begin : check_replies
      smte_pkg::rsp_type want;
      bit                differs;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_replies.size() == 0) begin
            report_mismatch("Unexpected response", '0, rsp_data);
         end else begin
            want = owed_replies.pop_front();
            differs = (rsp_data.reply_kind !== want.reply_kind) ||
                      (rsp_data.timer_slot !== want.timer_slot) ||
                      (rsp_data.expired_word !== want.expired_word) ||
                      (rsp_data.expired_queue !== want.expired_queue) ||
                      (rsp_data.is_last !== want.is_last);
            if (differs) report_mismatch("Response mismatch", want, rsp_data);
         end
      end
   end

   function automatic smte_pkg::req_type make_request(logic [2:0] op, int slot,
                                                      logic [31:0] delay,
                                                      logic [31:0] word, logic [2:0] dest);
      smte_pkg::req_type r;
      r.opcode      = op;
      r.slot_index  = 4'(slot);
      r.delay_ticks = delay;
      r.event_word  = word;
      r.dest_queue  = dest;
      return r;
   endfunction

   task automatic send_request(input smte_pkg::req_type req);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      timer_pool_apply(req);
   endtask

   function automatic int pick_slot(logic [1:0] want, bit need_loaded);
      int hits[$];
      for (int i = 0; i < smte_pkg::TIMER_SLOTS; i++)
         if (slot_state[i] == want && (slot_loaded[i] || !need_loaded)) hits.push_back(i);
      if (hits.size() == 0) return $urandom_range(smte_pkg::TIMER_SLOTS - 1);
      return hits[$urandom_range(hits.size() - 1)];
   endfunction

   function automatic logic [31:0] pick_delay();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55) return $urandom_range(6);
      if (roll < 70 && armed_list.size() != 0)
         return slot_due[armed_list[$urandom_range(armed_list.size() - 1)]] - tick_now;
      if (roll < 88) return $urandom_range(40, 7);
      if (roll < 95) return 32'hffff_ffff - $urandom_range(tick_now);
      return $urandom;
   endfunction

   task automatic test_pool_full();
      repeat (smte_pkg::TIMER_SLOTS + 1)
         send_request(make_request(smte_pkg::OP_ALLOC, 0, '0, '0, '0));
   endtask

   task automatic test_slot_lifecycle();
      send_request(make_request(smte_pkg::OP_INIT, 15, '0, 32'hffff_ffff, 3'd7));
      send_request(make_request(smte_pkg::OP_ARM, 15, '0, '0, '0));
      send_request(make_request(smte_pkg::OP_ARM, 15, 32'd5, '0, '0));
      send_request(make_request(smte_pkg::OP_FREE, 0, '0, '0, '0));
      send_request(make_request(smte_pkg::OP_FREE, 0, '0, '0, '0));
      send_request(make_request(smte_pkg::OP_ARM, 0, 32'd1, '0, '0));
      send_request(make_request(smte_pkg::OP_TICK, 0, '0, '0, '0));
   endtask

   task automatic test_unknown_and_wrap();
      send_request(make_request(OP_UNUSED_LAST, 15, '1, '1, '1));
      send_request(make_request(smte_pkg::OP_INIT, 14, '0, '0, '0));
      // The deadline wraps past zero and is already due on the next tick.
      send_request(make_request(smte_pkg::OP_ARM, 14, 32'hffff_ffff, '0, '0));
      send_request(make_request(smte_pkg::OP_TICK, 0, '0, '0, '0));
   endtask

   task automatic test_random_traffic(int count);
      smte_pkg::req_type req;
      int                roll;
      for (int k = 0; k < count; k++) begin
         no_idle = (k >= count / 3) && (k < count / 3 + 120);
         req.slot_index  = 4'($urandom);
         req.delay_ticks = $urandom;
         req.event_word  = $urandom;
         req.dest_queue  = 3'($urandom);
         roll = $urandom_range(99);
         if (roll < 14) begin
            req.opcode = smte_pkg::OP_ALLOC;
         end else if (roll < 24) begin
            req.opcode = smte_pkg::OP_FREE;
            if ($urandom_range(1)) req.slot_index = 4'(pick_slot(smte_pkg::ST_ARMED, 1'b0));
         end else if (roll < 40) begin
            req.opcode = smte_pkg::OP_INIT;
            if ($urandom_range(3) != 0)
               req.slot_index = 4'(pick_slot(smte_pkg::ST_ALLOC, 1'b0));
         end else if (roll < 66) begin
            req.opcode = smte_pkg::OP_ARM;
            if ($urandom_range(6) != 0)
               req.slot_index = 4'(pick_slot(smte_pkg::ST_ALLOC, 1'b1));
            req.delay_ticks = pick_delay();
         end else if (roll < 96) begin
            req.opcode = smte_pkg::OP_TICK;
         end else begin
            req.opcode = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
         end
         // A timer must carry event data before it can expire.
         if (req.opcode == smte_pkg::OP_ARM &&
             slot_state[req.slot_index] == smte_pkg::ST_ALLOC &&
             !slot_loaded[req.slot_index])
            req.opcode = smte_pkg::OP_INIT;
         send_request(req);
      end
      no_idle = 1'b0;
   endtask

   initial begin
      tick_now = '0;
      for (int i = 0; i < smte_pkg::TIMER_SLOTS; i++) begin
         slot_state[i]  = smte_pkg::ST_FREE;
         slot_due[i]    = '0;
         slot_word[i]   = '0;
         slot_dest[i]   = '0;
         slot_loaded[i] = 1'b0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_pool_full();
      test_slot_lifecycle();
      test_unknown_and_wrap();
      test_random_traffic(RANDOM_REQUESTS);
      @(negedge clock);
      req_valid <= 1'b0;
      while (owed_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_total == 0 && owed_replies.size() == 0) begin
         $display("sorted_multi_timer_engine_core test passed");
      end else begin
         $display("sorted_multi_timer_engine_core test failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("sorted_multi_timer_engine_core test failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/smte_pkg.sv
sv/smte_dp.sv
sv/smte_ctrl.sv
sv/sorted_multi_timer_engine_core.sv
test/tb.sv
